>>> src/lcdl_pkg.sv
// ----------------------------------------------------------------------------
// lcdl_pkg: shared types and constants for the display link frame handler
// Frame geometry, trailer and reply constants, result codes, and the job
// record that travels from the receive side to the reply side.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdl_pkg;

    // Frame geometry
    localparam int RX_FRAME_LEN = 13;
    localparam int TX_FRAME_LEN = 12;
    localparam int CNT_W        = $clog2(RX_FRAME_LEN + 1);
    localparam int RUN_LEN      = TX_FRAME_LEN + 1;   // status + reply bytes
    localparam int CKSUM_POS    = 5;                  // byte left out of the XOR
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Trailer bytes
    localparam logic [7:0] TRAILER_A   = 8'h32;
    localparam logic [7:0] TRAILER_B   = 8'h37;
    localparam logic [7:0] TRAILER_END = 8'h0E;

    // Reply constants
    localparam logic [7:0] TX_HEAD0 = 8'd65;
    localparam logic [7:0] TX_HEAD2 = 8'd48;

    // Register reset values
    localparam logic [7:0] FIXED_KEY_RST   = 8'd10;
    localparam logic [7:0] LEARNED_KEY_RST = 8'd2;
    localparam logic [7:0] KEY_LIMIT_RST   = 8'd50;

    localparam logic [6:0] SPEED_BASE = 7'd10;

    typedef enum logic [1:0] {
        CFG_FIXED_KEY   = 2'd0,
        CFG_INIT_KEY    = 2'd1,
        CFG_KEY_LIMIT   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic {
        IK_BYTE   = 1'b0,
        IK_RESYNC = 1'b1
    } item_kind_t;

    typedef enum logic {
        RK_STATUS = 1'b0,
        RK_REPLY  = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        FS_ACCEPTED    = 2'd0,
        FS_BAD_TRAILER = 2'd1,
        FS_BAD_CHECKSUM = 2'd2,
        FS_RESERVED    = 2'd3
    } frame_status_t;

    // Configuration write as seen by the receive side
    typedef struct packed {
        logic       wr;
        logic [1:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    // One completed frame: decoded status plus the sampled reply fields
    typedef struct packed {
        frame_status_t status;
        logic [2:0]    assist;
        logic          light;
        logic [4:0]    wheel;
        logic [6:0]    speed;
        logic [20:0]   pp;
        logic [21:0]   cp;
        logic [4:0]    battery;
        logic [15:0]   period;
        logic [7:0]    err;
        logic [7:0]    flags;
        logic [7:0]    power;
        logic [7:0]    temp;
        logic [7:0]    sum;
    } frame_job_t;

endpackage

`default_nettype wire

>>> src/lcdl_front.sv
// ----------------------------------------------------------------------------
// lcdl_front: receive side of the display link frame handler
// Collects received bytes, keeps the running XOR, checks trailer and
// checksum on the last byte, learns the checksum key and queues a job.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdl_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  item_kind,
    input  wire logic [7:0]            rx_byte,
    input  wire logic [15:0]           wheel_period,
    input  wire logic [7:0]            power_units,
    input  wire logic signed [7:0]     temperature_code,
    input  wire logic [7:0]            error_code,
    input  wire logic [4:0]            battery_level,
    input  wire logic [7:0]            moving_flags,
    input  wire lcdl_pkg::cfg_wr_t     cfg,
    input  wire logic                  q_full,
    output logic                       q_push,
    output lcdl_pkg::frame_job_t       q_data
);

    logic [lcdl_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] fixed_key_reg, key_limit_reg, learned_key_reg, learned_key_next;
    logic [7:0] frame_reg [lcdl_pkg::RX_FRAME_LEN-1];

    logic       accept, is_byte, last_byte;
    logic [7:0] x_full, cand;
    logic       trailer_ok, crc_ok;
    logic [5:0] speed_field;

    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign is_byte   = (item_kind == lcdl_pkg::IK_BYTE);
    assign last_byte = (cnt_reg == lcdl_pkg::CNT_W'(lcdl_pkg::RX_FRAME_LEN - 1));

    // Frame check on the final byte, which is the trailer end byte
    assign x_full     = xor_reg ^ rx_byte;
    assign trailer_ok = ((frame_reg[11] == lcdl_pkg::TRAILER_A) ||
                         (frame_reg[11] == lcdl_pkg::TRAILER_B)) &&
                        (rx_byte == lcdl_pkg::TRAILER_END);
    assign crc_ok     = ((x_full ^ fixed_key_reg) == frame_reg[lcdl_pkg::CKSUM_POS]) ||
                        ((x_full ^ learned_key_reg) == frame_reg[lcdl_pkg::CKSUM_POS]);
    assign cand       = x_full ^ frame_reg[lcdl_pkg::CKSUM_POS];
    assign speed_field = {frame_reg[4][5], frame_reg[2][7:3]};

    // Counter, XOR and key update
    always_comb
    begin
        cnt_next         = cnt_reg;
        xor_next         = xor_reg;
        learned_key_next = learned_key_reg;
        q_push           = 1'b0;
        if (accept)
        begin
            if (!is_byte)
            begin
                cnt_next = '0;
                xor_next = '0;
            end
            else if (last_byte)
            begin
                cnt_next = '0;
                xor_next = '0;
                q_push   = 1'b1;
                if (trailer_ok && !crc_ok && (cand <= key_limit_reg))
                begin
                    learned_key_next = cand;
                end
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != lcdl_pkg::CNT_W'(lcdl_pkg::CKSUM_POS))
                begin
                    xor_next = xor_reg ^ rx_byte;
                end
            end
        end
        if (cfg.wr && (cfg.index == lcdl_pkg::CFG_INIT_KEY))
        begin
            learned_key_next = cfg.data;
        end
    end

    // Job contents
    always_comb
    begin
        q_data         = '0;
        q_data.battery = battery_level;
        q_data.period  = wheel_period;
        q_data.err     = error_code;
        q_data.flags   = moving_flags;
        q_data.power   = power_units;
        q_data.temp    = temperature_code;
        q_data.sum     = {3'b000, battery_level} ^ lcdl_pkg::TX_HEAD2 ^
                         wheel_period[15:8] ^ wheel_period[7:0] ^
                         error_code ^ moving_flags ^ power_units ^ temperature_code;
        priority if (!trailer_ok)
        begin
            q_data.status = lcdl_pkg::FS_BAD_TRAILER;
        end
        else if (!crc_ok)
        begin
            q_data.status = lcdl_pkg::FS_BAD_CHECKSUM;
        end
        else
        begin
            q_data.status = lcdl_pkg::FS_ACCEPTED;
            q_data.assist = frame_reg[1][2:0];
            q_data.light  = frame_reg[1][7];
            q_data.wheel  = {frame_reg[2][2:0], frame_reg[4][7:6]};
            q_data.speed  = lcdl_pkg::SPEED_BASE + {1'b0, speed_field};
            q_data.pp     = {frame_reg[0], frame_reg[4][4], frame_reg[4][3],
                             frame_reg[4][2:0], frame_reg[3]};
            q_data.cp     = {frame_reg[7][6:5], frame_reg[10][4:2], frame_reg[9][3:0],
                             frame_reg[7][3:0], frame_reg[8][7:5], frame_reg[6][2:0],
                             frame_reg[6][5:3]};
        end
    end

    // Control state and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            xor_reg         <= '0;
            fixed_key_reg   <= lcdl_pkg::FIXED_KEY_RST;
            key_limit_reg   <= lcdl_pkg::KEY_LIMIT_RST;
            learned_key_reg <= lcdl_pkg::LEARNED_KEY_RST;
        end
        else
        begin
            cnt_reg         <= cnt_next;
            xor_reg         <= xor_next;
            learned_key_reg <= learned_key_next;
            if (cfg.wr && (cfg.index == lcdl_pkg::CFG_FIXED_KEY))
            begin
                fixed_key_reg <= cfg.data;
            end
            if (cfg.wr && (cfg.index == lcdl_pkg::CFG_KEY_LIMIT))
            begin
                key_limit_reg <= cfg.data;
            end
        end
    end

    // Frame byte capture; the last byte is used straight from the input
    always_ff @(posedge clk)
    begin
        if (accept && is_byte && !last_byte)
        begin
            frame_reg[cnt_reg] <= rx_byte;
        end
    end

endmodule

`default_nettype wire

>>> src/lcdl_queue.sv
// ----------------------------------------------------------------------------
// lcdl_queue: short job queue between receive side and reply side
// Two-entry FIFO of frame jobs with full and valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdl_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lcdl_pkg::frame_job_t  push_data,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       valid,
    output lcdl_pkg::frame_job_t       data
);

    lcdl_pkg::frame_job_t entry_reg [lcdl_pkg::QUEUE_DEPTH];
    logic [lcdl_pkg::QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [lcdl_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full    = (count_reg == lcdl_pkg::QCNT_W'(lcdl_pkg::QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign data    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/lcdl_back.sv
// ----------------------------------------------------------------------------
// lcdl_back: reply side of the display link frame handler
// Takes one job from the queue and plays out the status item followed by
// the twelve reply bytes through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdl_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire lcdl_pkg::frame_job_t  q_data,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       result_kind,
    output logic [7:0]                 tx_byte,
    output logic                       last_of_run,
    output logic [1:0]                 frame_status,
    output logic [2:0]                 assist_mode,
    output logic                       light_on,
    output logic [4:0]                 wheel_code,
    output logic [6:0]                 max_speed_kmh,
    output logic [20:0]                p_params,
    output logic [21:0]                c_params
);

    localparam logic [lcdl_pkg::CNT_W-1:0] LAST_IDX = lcdl_pkg::CNT_W'(lcdl_pkg::RUN_LEN - 1);

    lcdl_pkg::frame_job_t job_reg;
    logic busy_reg;
    logic [lcdl_pkg::CNT_W-1:0] idx_reg;
    logic out_valid_reg;

    logic       load, run_end;
    logic [7:0] reply_byte;

    assign load    = busy_reg && (!out_valid_reg || !out_stall);
    assign run_end = load && (idx_reg == LAST_IDX);
    assign q_pop   = q_valid && (!busy_reg || run_end);
    assign out_valid = out_valid_reg;

    // Reply byte for the current position (position 0 is the status item)
    always_comb
    begin
        unique case (idx_reg)
            4'd1:    reply_byte = lcdl_pkg::TX_HEAD0;
            4'd2:    reply_byte = {3'b000, job_reg.battery};
            4'd3:    reply_byte = lcdl_pkg::TX_HEAD2;
            4'd4:    reply_byte = job_reg.period[15:8];
            4'd5:    reply_byte = job_reg.period[7:0];
            4'd6:    reply_byte = job_reg.err;
            4'd7:    reply_byte = job_reg.sum;
            4'd8:    reply_byte = job_reg.flags;
            4'd9:    reply_byte = job_reg.power;
            4'd10:   reply_byte = job_reg.temp;
            default: reply_byte = 8'h00;
        endcase
    end

    // Run sequencing and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (run_end)
            begin
                busy_reg <= 1'b0;
            end
            else if (load)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Job capture and output payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_data;
        end
        if (load)
        begin
            if (idx_reg == '0)
            begin
                result_kind   <= lcdl_pkg::RK_STATUS;
                tx_byte       <= 8'h00;
                last_of_run   <= 1'b0;
                frame_status  <= job_reg.status;
                assist_mode   <= job_reg.assist;
                light_on      <= job_reg.light;
                wheel_code    <= job_reg.wheel;
                max_speed_kmh <= job_reg.speed;
                p_params      <= job_reg.pp;
                c_params      <= job_reg.cp;
            end
            else
            begin
                result_kind   <= lcdl_pkg::RK_REPLY;
                tx_byte       <= reply_byte;
                last_of_run   <= (idx_reg == LAST_IDX);
                frame_status  <= lcdl_pkg::FS_ACCEPTED;
                assist_mode   <= '0;
                light_on      <= 1'b0;
                wheel_code    <= '0;
                max_speed_kmh <= '0;
                p_params      <= '0;
                c_params      <= '0;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/lcd_display_link_frame_handler.sv
// ----------------------------------------------------------------------------
// lcd_display_link_frame_handler: display link frame receiver and replier
// Usage:
//   Input channel (in_valid / in_stall) carries one item per cycle: either a
//   received byte or a resync that restarts framing. Up to one item is taken
//   every cycle; in_stall rises only when the two-entry job queue is full.
//   On the 13th byte of a frame one job is queued; the output channel
//   (out_valid / out_stall) then gives one status item and the 12 reply
//   bytes, one item per cycle while out_stall is low, last_of_run marking the final reply byte.
//   Path: with the reply side idle, the completing byte is written into the
//   queue, the job is then taken into the job register of the sequencer,
//   and the status item is then registered in its single output stage; the
//   13 items of a run follow without gaps while the receiver does not stall.
//   Configuration (cfg_valid / cfg_ready) is always ready; writing the
//   initial learned key also loads the learned key.
//   Reset clears framing, the queue and the output stage and restores the
//   register defaults. A stall on the output holds the item in place while
//   frames keep being received until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module lcd_display_link_frame_handler (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              item_kind,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [15:0]       wheel_period,
    input  wire logic [7:0]        power_units,
    input  wire logic signed [7:0] temperature_code,
    input  wire logic [7:0]        error_code,
    input  wire logic [4:0]        battery_level,
    input  wire logic [7:0]        moving_flags,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   result_kind,
    output logic [7:0]             tx_byte,
    output logic                   last_of_run,
    output logic [1:0]             frame_status,
    output logic [2:0]             assist_mode,
    output logic                   light_on,
    output logic [4:0]             wheel_code,
    output logic [6:0]             max_speed_kmh,
    output logic [20:0]            p_params,
    output logic [21:0]            c_params,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data
);

    lcdl_pkg::cfg_wr_t    cfg;
    lcdl_pkg::frame_job_t push_job, head_job;
    logic q_full, q_push, q_pop, q_valid;

    assign cfg_ready = 1'b1;
    assign cfg.wr    = cfg_valid && cfg_ready;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    lcdl_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .item_kind        (item_kind),
        .rx_byte          (rx_byte),
        .wheel_period     (wheel_period),
        .power_units      (power_units),
        .temperature_code (temperature_code),
        .error_code       (error_code),
        .battery_level    (battery_level),
        .moving_flags     (moving_flags),
        .cfg              (cfg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (push_job)
    );

    lcdl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (head_job)
    );

    lcdl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (head_job),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .tx_byte       (tx_byte),
        .last_of_run   (last_of_run),
        .frame_status  (frame_status),
        .assist_mode   (assist_mode),
        .light_on      (light_on),
        .wheel_code    (wheel_code),
        .max_speed_kmh (max_speed_kmh),
        .p_params      (p_params),
        .c_params      (c_params)
    );

endmodule

`default_nettype wire

>>> src/lcdl_checker.sv
// ----------------------------------------------------------------------------
// lcdl_checker: port-level checks for the display link frame handler
// Watches the output channel for reset behavior, hold under stall and the
// shape of status and reply items.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdl_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        result_kind,
    input wire logic [7:0]  tx_byte,
    input wire logic        last_of_run,
    input wire logic [1:0]  frame_status,
    input wire logic [2:0]  assist_mode
);

    // No output item while in reset
    a_no_out_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // A stalled item holds
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(result_kind))
        else $error("stalled output item changed");

    // Status items carry no reply byte and never end a run
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == lcdl_pkg::RK_STATUS) |-> (tx_byte == 8'h00) && !last_of_run)
        else $error("status item carries reply content");

    // Reply items carry no frame status or decoded settings
    a_reply_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == lcdl_pkg::RK_REPLY) |->
        (frame_status == lcdl_pkg::FS_ACCEPTED) && (assist_mode == 3'd0))
        else $error("reply item carries status content");

    // Rejected frames never report decoded settings
    a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frame_status != lcdl_pkg::FS_ACCEPTED) |-> (assist_mode == 3'd0))
        else $error("rejected frame reports settings");

endmodule

bind lcd_display_link_frame_handler lcdl_checker u_lcdl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_kind  (result_kind),
    .tx_byte      (tx_byte),
    .last_of_run  (last_of_run),
    .frame_status (frame_status),
    .assist_mode  (assist_mode)
);

`default_nettype wire

>>> sim/tb_lcd_display_link_frame_handler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcd_display_link_frame_handler: self-checking bench for the frame handler
// Feeds display-link bytes and resync items, and mirrors the framing, the
// checksum with its fixed and learned keys, and the reply build. Each status
// and reply item the block returns is checked field by field against that
// mirror. Both sides idle and stall at random. One long output hold-off
// fills the job queue. The key registers are swept through their extremes.
// ----------------------------------------------------------------------------

module tb_lcd_display_link_frame_handler;

    localparam int SETTLE_CYCLES = 8;     // output pipeline depth plus margin
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake
    localparam int PRINT_LIMIT   = 100;

    typedef enum logic [2:0] {
        FR_FIXED_KEY,
        FR_LEARNED_KEY,
        FR_LEARNABLE,
        FR_BAD_SUM,
        FR_BAD_TRAILER
    } frame_flavor_t;

    // One input item: a link byte or a resync, plus the telemetry for the reply
    typedef struct packed {
        lcdl_pkg::item_kind_t kind;
        logic [7:0]           rx;
        logic [15:0]          period;
        logic [7:0]           power;
        logic signed [7:0]    temp;
        logic [7:0]           err;
        logic [4:0]           batt;
        logic [7:0]           flags;
    } link_item_t;

    // One output item: status with decoded settings, or one reply byte
    typedef struct packed {
        lcdl_pkg::result_kind_t  kind;
        logic [7:0]              txb;
        logic                    last;
        lcdl_pkg::frame_status_t status;
        logic [2:0]              assist;
        logic                    light;
        logic [4:0]              wheel;
        logic [6:0]              speed;
        logic [20:0]             pp;
        logic [21:0]             cp;
    } run_item_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              item_kind;
    logic [7:0]        rx_byte;
    logic [15:0]       wheel_period;
    logic [7:0]        power_units;
    logic signed [7:0] temperature_code;
    logic [7:0]        error_code;
    logic [4:0]        battery_level;
    logic [7:0]        moving_flags;
    logic              out_valid;
    logic              out_stall;
    logic              result_kind;
    logic [7:0]        tx_byte;
    logic              last_of_run;
    logic [1:0]        frame_status;
    logic [2:0]        assist_mode;
    logic              light_on;
    logic [4:0]        wheel_code;
    logic [6:0]        max_speed_kmh;
    logic [20:0]       p_params;
    logic [21:0]       c_params;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [7:0]        cfg_data;

    // Mirror of the block's registers and framing state
    logic [7:0] ky_fixed;
    logic [7:0] ky_init;
    logic [7:0] ky_limit;
    logic [7:0] ky_learned;
    int         rx_count;
    logic [7:0] rx_xor;
    logic [7:0] rx_frame [lcdl_pkg::RX_FRAME_LEN];

    run_item_t reply_run_q [$];

    // Run control and tallies
    logic no_idle;
    logic hold_req;
    int   hold_left;
    int   idle_run;
    int   mismatches;
    int   n_items;
    int   n_results;
    int   n_accepted;
    int   n_bad_trailer;
    int   n_bad_sum;
    int   n_learned;
    int   n_resync;

    lcd_display_link_frame_handler u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .item_kind        (item_kind),
        .rx_byte          (rx_byte),
        .wheel_period     (wheel_period),
        .power_units      (power_units),
        .temperature_code (temperature_code),
        .error_code       (error_code),
        .battery_level    (battery_level),
        .moving_flags     (moving_flags),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .tx_byte          (tx_byte),
        .last_of_run      (last_of_run),
        .frame_status     (frame_status),
        .assist_mode      (assist_mode),
        .light_on         (light_on),
        .wheel_code       (wheel_code),
        .max_speed_kmh    (max_speed_kmh),
        .p_params         (p_params),
        .c_params         (c_params),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Frame mirror: absorbs one accepted item, queues the run it causes
    // ------------------------------------------------------------------------
    task automatic absorb_rx_item(input link_item_t it);
        logic [7:0] x;
        logic [7:0] cand;
        logic [7:0] sum;
        logic [7:0] rb [lcdl_pkg::TX_FRAME_LEN];
        logic       trailer_ok;
        logic       sum_ok;
        run_item_t  st;
        run_item_t  rp;
        if (it.kind == lcdl_pkg::IK_RESYNC)
        begin
            rx_count = 0;
            rx_xor   = '0;
            n_resync++;
            return;
        end
        if (rx_count >= lcdl_pkg::RX_FRAME_LEN)
            rx_count = 0;
        rx_frame[rx_count] = it.rx;
        if (rx_count != lcdl_pkg::CKSUM_POS)
            rx_xor ^= it.rx;
        rx_count++;
        if (rx_count < lcdl_pkg::RX_FRAME_LEN)
            return;

        x        = rx_xor;
        rx_count = 0;
        rx_xor   = '0;

        trailer_ok = (rx_frame[11] == lcdl_pkg::TRAILER_A ||
                      rx_frame[11] == lcdl_pkg::TRAILER_B)
                     && rx_frame[12] == lcdl_pkg::TRAILER_END;
        sum_ok     = ((x ^ ky_fixed) == rx_frame[lcdl_pkg::CKSUM_POS])
                     || ((x ^ ky_learned) == rx_frame[lcdl_pkg::CKSUM_POS]);

        // status item; decoded fields stay zero on a rejected frame
        st        = '0;
        st.kind   = lcdl_pkg::RK_STATUS;
        st.status = lcdl_pkg::FS_ACCEPTED;
        if (!trailer_ok)
        begin
            st.status = lcdl_pkg::FS_BAD_TRAILER;
            n_bad_trailer++;
        end
        else if (!sum_ok)
        begin
            st.status = lcdl_pkg::FS_BAD_CHECKSUM;
            n_bad_sum++;
            cand = x ^ rx_frame[lcdl_pkg::CKSUM_POS];
            if (cand <= ky_limit)
            begin
                ky_learned = cand;
                n_learned++;
            end
        end
        else
        begin
            st.assist = rx_frame[1][2:0];
            st.light  = rx_frame[1][7];
            st.wheel  = {rx_frame[2][2:0], rx_frame[4][7:6]};
            st.speed  = lcdl_pkg::SPEED_BASE + {1'b0, rx_frame[4][5], rx_frame[2][7:3]};
            st.pp     = {rx_frame[0], rx_frame[4][4], rx_frame[4][3],
                         rx_frame[4][2:0], rx_frame[3]};
            st.cp     = {rx_frame[7][6:5], rx_frame[10][4:2], rx_frame[9][3:0],
                         rx_frame[7][3:0], rx_frame[8][7:5], rx_frame[6][2:0],
                         rx_frame[6][5:3]};
            n_accepted++;
        end
        reply_run_q.push_back(st);

        // reply bytes, checksum in byte 6 over bytes 1..11
        rb[0]  = lcdl_pkg::TX_HEAD0;
        rb[1]  = {3'b000, it.batt};
        rb[2]  = lcdl_pkg::TX_HEAD2;
        rb[3]  = it.period[15:8];
        rb[4]  = it.period[7:0];
        rb[5]  = it.err;
        rb[6]  = '0;
        rb[7]  = it.flags;
        rb[8]  = it.power;
        rb[9]  = it.temp;
        rb[10] = '0;
        rb[11] = '0;
        sum = '0;
        for (int j = 1; j < lcdl_pkg::TX_FRAME_LEN; j++)
            sum ^= rb[j];
        rb[6] = sum;
        for (int k = 0; k < lcdl_pkg::TX_FRAME_LEN; k++)
        begin
            rp      = '0;
            rp.kind = lcdl_pkg::RK_REPLY;
            rp.txb  = rb[k];
            rp.last = (k == lcdl_pkg::TX_FRAME_LEN - 1);
            reply_run_q.push_back(rp);
        end
    endtask

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        // keep the log bounded on a badly broken build
        if (mismatches <= PRINT_LIMIT)
            $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Output checker: compares each accepted item with the oldest one due
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : run_checker
        run_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (reply_run_q.size() == 0)
                report_mismatch("output item with nothing due", {31'b0, result_kind}, 0);
            else
            begin
                want = reply_run_q.pop_front();
                check_field("result_kind", 32'(result_kind), 32'(want.kind));
                check_field("tx_byte", 32'(tx_byte), 32'(want.txb));
                check_field("last_of_run", 32'(last_of_run), 32'(want.last));
                check_field("frame_status", 32'(frame_status), 32'(want.status));
                check_field("assist_mode", 32'(assist_mode), 32'(want.assist));
                check_field("light_on", 32'(light_on), 32'(want.light));
                check_field("wheel_code", 32'(wheel_code), 32'(want.wheel));
                check_field("max_speed_kmh", 32'(max_speed_kmh), 32'(want.speed));
                check_field("p_params", 32'(p_params), 32'(want.pp));
                check_field("c_params", 32'(c_params), 32'(want.cp));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < 6);
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run when no handshake happens for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic link_item_t rand_reply();
        link_item_t it;
        it.kind   = lcdl_pkg::IK_BYTE;
        it.rx     = 8'($urandom_range(0, 255));
        it.period = 16'($urandom_range(0, 65535));
        it.power  = 8'($urandom_range(0, 255));
        it.temp   = 8'($urandom_range(0, 255));
        it.err    = 8'($urandom_range(0, 255));
        it.batt   = 5'($urandom_range(0, 16));
        it.flags  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Sends one item, with an occasional gap before it
    task automatic send_item(input link_item_t it);
        if (!no_idle && $urandom_range(0, 99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid         <= 1'b1;
        item_kind        <= it.kind;
        rx_byte          <= it.rx;
        wheel_period     <= it.period;
        power_units      <= it.power;
        temperature_code <= it.temp;
        error_code       <= it.err;
        battery_level    <= it.batt;
        moving_flags     <= it.flags;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        absorb_rx_item(it);
        n_items++;
    endtask

    // Sends a run of bytes that never completes a frame, then a resync
    task automatic send_fragment(input int len);
        link_item_t it;
        for (int i = 0; i < len; i++)
            send_item(rand_reply());
        it      = rand_reply();
        it.kind = lcdl_pkg::IK_RESYNC;
        send_item(it);
    endtask

    // Builds and sends one 13-byte frame; content bits come from and_m/or_m
    task automatic send_frame(input frame_flavor_t flavor, input link_item_t reply,
                              input logic [7:0] and_m, input logic [7:0] or_m);
        logic [7:0] fb [lcdl_pkg::RX_FRAME_LEN];
        logic [7:0] x;
        link_item_t it;
        for (int i = 0; i < lcdl_pkg::RX_FRAME_LEN; i++)
            fb[i] = (8'($urandom_range(0, 255)) & and_m) | or_m;
        fb[11] = $urandom_range(0, 1) ? lcdl_pkg::TRAILER_A : lcdl_pkg::TRAILER_B;
        fb[12] = lcdl_pkg::TRAILER_END;
        if (flavor == FR_BAD_TRAILER)
        begin
            if ($urandom_range(0, 1))
                do fb[11] = 8'($urandom_range(0, 255));
                while (fb[11] == lcdl_pkg::TRAILER_A || fb[11] == lcdl_pkg::TRAILER_B);
            else
                do fb[12] = 8'($urandom_range(0, 255));
                while (fb[12] == lcdl_pkg::TRAILER_END);
        end

        x = '0;
        for (int i = 0; i < lcdl_pkg::RX_FRAME_LEN; i++)
            if (i != lcdl_pkg::CKSUM_POS)
                x ^= fb[i];
        case (flavor)
            FR_FIXED_KEY:   fb[lcdl_pkg::CKSUM_POS] = x ^ ky_fixed;
            FR_LEARNED_KEY: fb[lcdl_pkg::CKSUM_POS] = x ^ ky_learned;
            FR_LEARNABLE:   fb[lcdl_pkg::CKSUM_POS] = x ^ 8'($urandom_range(0, ky_limit));
            default:        fb[lcdl_pkg::CKSUM_POS] = $urandom_range(0, 1)
                                                      ? (x ^ ky_fixed)
                                                      : 8'($urandom_range(0, 255));
        endcase

        for (int i = 0; i < lcdl_pkg::RX_FRAME_LEN; i++)
        begin
            it      = reply;
            it.kind = lcdl_pkg::IK_BYTE;
            it.rx   = fb[i];
            send_item(it);
        end
    endtask

    // Drops valid, waits until every due item has come, then lets the block settle
    task automatic settle_link();
        in_valid <= 1'b0;
        while (reply_run_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all key registers, plus the spare index, in one burst
    task automatic write_settings(input logic [7:0] fk, input logic [7:0] ik,
                                  input logic [7:0] lim);
        lcdl_pkg::cfg_index_t idx;
        logic [7:0] val;
        for (int i = 0; i < 4; i++)
        begin
            idx = lcdl_pkg::cfg_index_t'(i);
            case (idx)
                lcdl_pkg::CFG_FIXED_KEY: val = fk;
                lcdl_pkg::CFG_INIT_KEY:  val = ik;
                lcdl_pkg::CFG_KEY_LIMIT: val = lim;
                default:                 val = 8'($urandom_range(0, 255));
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                lcdl_pkg::CFG_FIXED_KEY: ky_fixed = val;
                lcdl_pkg::CFG_INIT_KEY:
                begin
                    ky_init    = val;
                    ky_learned = val;
                end
                lcdl_pkg::CFG_KEY_LIMIT: ky_limit = val;
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Resync alone and an incomplete frame: no output expected
    task automatic test_resync_and_fragment();
        send_fragment(0);
        send_fragment(6);
    endtask

    // Accepted frames with all-ones and all-zeros content and telemetry extremes
    task automatic test_accepted_extremes();
        link_item_t hi;
        link_item_t lo;
        hi        = '0;
        hi.kind   = lcdl_pkg::IK_BYTE;
        hi.period = 16'hFFFF;
        hi.power  = 8'hFF;
        hi.temp   = 8'sd127;
        hi.err    = 8'hFF;
        hi.batt   = 5'd16;
        hi.flags  = 8'hFF;
        lo        = '0;
        lo.kind   = lcdl_pkg::IK_BYTE;
        lo.temp   = -8'sd128;
        send_frame(FR_FIXED_KEY, hi, 8'hFF, 8'hFF);
        send_frame(FR_FIXED_KEY, lo, 8'h00, 8'h00);
    endtask

    // Learn a key from a checksum miss, use it, then a broken trailer
    task automatic test_key_learning();
        send_frame(FR_LEARNABLE, rand_reply(), 8'hFF, 8'h00);
        send_frame(FR_LEARNED_KEY, rand_reply(), 8'hFF, 8'h00);
        send_frame(FR_BAD_TRAILER, rand_reply(), 8'hFF, 8'h00);
    endtask

    // Mostly well-formed frames of random content, some broken ones and noise
    task automatic test_random_traffic(input int n);
        int stop_at;
        int pick;
        stop_at = n_items + n;
        while (n_items < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_frame(FR_FIXED_KEY, rand_reply(), 8'hFF, 8'h00);
            else if (pick < 60)
                send_frame(FR_LEARNED_KEY, rand_reply(), 8'hFF, 8'h00);
            else if (pick < 72)
                send_frame(FR_LEARNABLE, rand_reply(), 8'hFF, 8'h00);
            else if (pick < 80)
                send_frame(FR_BAD_SUM, rand_reply(), 8'hFF, 8'h00);
            else if (pick < 88)
                send_frame(FR_BAD_TRAILER, rand_reply(), 8'hFF, 8'h00);
            else if (pick < 96)
                send_fragment($urandom_range(1, lcdl_pkg::RX_FRAME_LEN - 1));
            else
                send_fragment(0);
        end
    endtask

    // Register extremes: one phase with no idling on either side
    task automatic test_register_extremes();
        settle_link();
        no_idle = 1'b1;
        write_settings(8'h00, 8'hFF, 8'hFF);
        test_random_traffic(90);
        settle_link();
        no_idle = 1'b0;
        write_settings(8'hFF, 8'h00, 8'h00);
        test_random_traffic(90);
        settle_link();
    endtask

    // Long receiver hold-off while frames keep coming: the queue fills
    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (4) send_frame(FR_FIXED_KEY, rand_reply(), 8'hFF, 8'h00);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        item_kind        <= lcdl_pkg::IK_BYTE;
        rx_byte          <= '0;
        wheel_period     <= '0;
        power_units      <= '0;
        temperature_code <= '0;
        error_code       <= '0;
        battery_level    <= '0;
        moving_flags     <= '0;
        out_stall        <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= lcdl_pkg::CFG_FIXED_KEY;
        cfg_data         <= '0;
        no_idle       = 1'b0;
        hold_req      = 1'b0;
        hold_left     = 0;
        idle_run      = 0;
        mismatches    = 0;
        n_items       = 0;
        n_results     = 0;
        n_accepted    = 0;
        n_bad_trailer = 0;
        n_bad_sum     = 0;
        n_learned     = 0;
        n_resync      = 0;
        ky_fixed      = lcdl_pkg::FIXED_KEY_RST;
        ky_init       = lcdl_pkg::LEARNED_KEY_RST;
        ky_limit      = lcdl_pkg::KEY_LIMIT_RST;
        ky_learned    = lcdl_pkg::LEARNED_KEY_RST;
        rx_count      = 0;
        rx_xor        = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_settings(lcdl_pkg::FIXED_KEY_RST, lcdl_pkg::LEARNED_KEY_RST,
                       lcdl_pkg::KEY_LIMIT_RST);
        test_resync_and_fragment();
        test_accepted_extremes();
        test_key_learning();
        test_random_traffic(90);
        test_register_extremes();

        write_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 60)),
                       8'($urandom_range(20, 120)));
        test_output_backpressure();
        test_random_traffic(40);
        settle_link();

        $display("Sent %0d items: %0d frames accepted, %0d bad trailer, %0d bad checksum",
                 n_items, n_accepted, n_bad_trailer, n_bad_sum);
        $display("%0d keys learned, %0d resyncs, %0d output items checked, %0d mismatches",
                 n_learned, n_resync, n_results, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> lcd_display_link_frame_handler.f
src/lcdl_pkg.sv
src/lcdl_front.sv
src/lcdl_queue.sv
src/lcdl_back.sv
src/lcd_display_link_frame_handler.sv
src/lcdl_checker.sv
sim/tb_lcd_display_link_frame_handler.sv
